// ===== hdl/lpmc_pkg.sv =====
// Shared types and constants of the linear partition minimum capacity block.
package lpmc_pkg;

  localparam int CAP_W   = 26;
  localparam int LIMIT_W = 11;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [0:0] REG_GROUP_LIMIT = 1'b0;

  typedef struct packed {
    logic load;
    logic init_search;
    logic calc_mid;
    logic step_pass;
    logic eval;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic range_ok;
    logic pass_done;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/lpmc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lpmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/lpmc_ctrl.sv =====
// Controller state machine sequencing loading, binary search probes and result output.
module lpmc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_item_i,
  output logic              in_ready_o,
  input  lpmc_pkg::sts_t    sts_i,
  output lpmc_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_PROBE = 3'd2;
  localparam logic [2:0] ST_PASS  = 3'd3;
  localparam logic [2:0] ST_EVAL  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i && last_item_i) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.init_search = 1'b1;
        state_d           = ST_PROBE;
      end
      ST_PROBE: begin
        if (sts_i.range_ok) begin
          cmd_o.calc_mid = 1'b1;
          state_d        = ST_PASS;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_PASS: begin
        cmd_o.step_pass = 1'b1;
        if (sts_i.pass_done) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = ST_PROBE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/lpmc_dp.sv =====
// Datapath: item store, running total, search bounds, greedy pass and output register.
module lpmc_dp #(
  parameter int MAX_ITEMS   = 1024,
  parameter int LENGTH_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lpmc_pkg::cmd_t               cmd_i,
  output lpmc_pkg::sts_t               sts_o,
  input  logic [LENGTH_BITS-1:0]       item_length_i,
  input  logic [lpmc_pkg::LIMIT_W-1:0] group_limit_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [lpmc_pkg::CAP_W-1:0]   min_capacity_o,
  output logic                         overflow_o
);

  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int TOT_W = LENGTH_BITS + CW;
  localparam int SW    = TOT_W + 1;
  localparam int GW    = (CW > lpmc_pkg::LIMIT_W) ? CW : lpmc_pkg::LIMIT_W;

  logic [CW-1:0]          count_q, count_d;
  logic [TOT_W-1:0]       total_q, total_d;
  logic                   dropped_q, dropped_d;
  logic [SW-1:0]          lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [TOT_W-1:0]       best_q, best_d;
  logic [SW-1:0]          acc_q, acc_d;
  logic [CW-1:0]          groups_q, groups_d;
  logic                   fail_q, fail_d;
  logic [CW-1:0]          rd_idx_q, rd_idx_d;
  logic                   rd_vld_q, rd_vld_d;
  logic                   out_valid_q, out_valid_d;
  logic [lpmc_pkg::CAP_W-1:0] out_cap_q, out_cap_d;
  logic                   out_ovf_q, out_ovf_d;

  logic                   store_we;
  logic                   rd_issue;
  logic [LENGTH_BITS-1:0] rd_data;
  logic [SW-1:0]          v_ext;
  logic [SW-1:0]          acc_sum;
  logic [SW-1:0]          total_ext;
  logic [GW-1:0]          limit_eff;
  logic                   probe_ok;
  logic [TOT_W+lpmc_pkg::CAP_W-1:0] best_wide;

  assign store_we  = cmd_i.load && (count_q < CW'(MAX_ITEMS));
  assign rd_issue  = cmd_i.step_pass && (rd_idx_q < count_q);
  assign v_ext     = SW'(rd_data);
  assign acc_sum   = acc_q + v_ext;
  assign total_ext = SW'(total_q);
  assign limit_eff = (group_limit_i == '0) ? GW'(1) : GW'(group_limit_i);
  assign probe_ok  = !fail_q && (GW'(groups_q) <= limit_eff);
  assign best_wide = {{lpmc_pkg::CAP_W{1'b0}}, best_q};

  lpmc_ram #(
    .WIDTH (LENGTH_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (item_length_i),
    .re_i    (rd_issue),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  always_comb begin
    count_d     = count_q;
    total_d     = total_q;
    dropped_d   = dropped_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    best_d      = best_q;
    acc_d       = acc_q;
    groups_d    = groups_q;
    fail_d      = fail_q;
    rd_idx_d    = rd_idx_q;
    rd_vld_d    = rd_vld_q;
    out_valid_d = out_valid_q;
    out_cap_d   = out_cap_q;
    out_ovf_d   = out_ovf_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.load) begin
      if (store_we) begin
        count_d = count_q + CW'(1);
        total_d = total_q + TOT_W'(item_length_i);
      end else begin
        dropped_d = 1'b1;
      end
    end

    if (cmd_i.init_search) begin
      lo_d   = SW'(1);
      hi_d   = (total_q == '0) ? SW'(1) : total_ext;
      best_d = (total_q == '0) ? TOT_W'(1) : total_q;
    end

    if (cmd_i.calc_mid) begin
      mid_d    = lo_q + ((hi_q - lo_q) >> 1);
      acc_d    = '0;
      groups_d = CW'(1);
      fail_d   = 1'b0;
      rd_idx_d = '0;
      rd_vld_d = 1'b0;
    end

    if (cmd_i.step_pass) begin
      rd_vld_d = rd_issue;
      if (rd_issue) begin
        rd_idx_d = rd_idx_q + CW'(1);
      end
      if (rd_vld_q) begin
        if (v_ext > mid_q) begin
          fail_d = 1'b1;
        end
        if (acc_sum > mid_q) begin
          acc_d    = v_ext;
          groups_d = groups_q + CW'(1);
        end else begin
          acc_d = acc_sum;
        end
      end
    end

    if (cmd_i.eval) begin
      if (probe_ok) begin
        best_d = mid_q[TOT_W-1:0];
        hi_d   = mid_q - SW'(1);
      end else begin
        lo_d = mid_q + SW'(1);
      end
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_cap_d   = best_wide[lpmc_pkg::CAP_W-1:0];
      out_ovf_d   = dropped_q;
      count_d     = '0;
      total_d     = '0;
      dropped_d   = 1'b0;
      rd_idx_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      total_q     <= '0;
      dropped_q   <= 1'b0;
      lo_q        <= SW'(1);
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      total_q     <= total_d;
      dropped_q   <= dropped_d;
      lo_q        <= lo_d;
      rd_idx_q    <= rd_idx_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    best_q    <= best_d;
    acc_q     <= acc_d;
    groups_q  <= groups_d;
    fail_q    <= fail_d;
    out_cap_q <= out_cap_d;
    out_ovf_q <= out_ovf_d;
  end

  assign sts_o.range_ok  = (lo_q <= hi_q);
  assign sts_o.pass_done = (rd_idx_q == count_q) && !rd_vld_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign min_capacity_o = out_cap_q;
  assign overflow_o     = out_ovf_q;

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ITEMS))
    else $error("Stored item count exceeds the store depth.");

  a_read_index_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_idx_q <= count_q)
    else $error("Pass read index ran beyond the stored items.");

  a_lower_bound_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q != '0)
    else $error("Search lower bound fell to zero.");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (count_q == '0) && (total_q == '0) && !dropped_q && out_valid_q)
    else $error("Set was not cleared when its result was emitted.");
`endif

endmodule

// ===== hdl/linear_partition_min_capacity_top.sv =====
// Top level of the linear partition minimum capacity block.
// Items arrive as beats on the input channel (item_length_i, last_item_i) and are
// stored in order, one beat per cycle while the block is idle, as a running total
// is kept. A beat with last_item_i set starts a binary search over capacities
// 1..total; each probe is a greedy pass that reads the store once through its
// single read port. One result beat (min_capacity_o, overflow_o) follows each set.
// A set takes P probes, at most floor(log2(total)) + 1, or one when the total is
// zero. Input is refused during the search. Items beyond MAX_ITEMS are dropped and
// flagged by overflow_o. The result sits in an output register; if the receiver
// stalls, the next set may load and be searched but its result waits for the
// register to be freed. group_limit is written through the APB-style port at
// address 0; the user must write it only while the block is idle, as the block
// itself does not enforce this.
// Reset empties the set, drops any pending result and sets group_limit to 1; the
// store itself needs no clearing.
module linear_partition_min_capacity_top #(
  parameter int MAX_ITEMS   = 1024,
  parameter int LENGTH_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [LENGTH_BITS-1:0]        item_length_i,
  input  logic                          last_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lpmc_pkg::CAP_W-1:0]    min_capacity_o,
  output logic                          overflow_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpmc_pkg::ADDR_W-1:0]   paddr,
  input  logic [lpmc_pkg::DATA_W-1:0]   pwdata,
  output logic [lpmc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [lpmc_pkg::LIMIT_W-1:0] group_limit_q;
  logic                         reg_sel;
  lpmc_pkg::cmd_t               cmd;
  lpmc_pkg::sts_t               sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2:2] == lpmc_pkg::REG_GROUP_LIMIT);
  assign prdata  = reg_sel ? lpmc_pkg::DATA_W'(group_limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_limit_q <= lpmc_pkg::LIMIT_W'(1);
    end else if (psel && penable && pwrite && reg_sel) begin
      group_limit_q <= pwdata[lpmc_pkg::LIMIT_W-1:0];
    end
  end

  lpmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_item_i (last_item_i),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lpmc_dp #(
    .MAX_ITEMS   (MAX_ITEMS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .item_length_i  (item_length_i),
    .group_limit_i  (group_limit_q),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .min_capacity_o (min_capacity_o),
    .overflow_o     (overflow_o)
  );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the linear partition minimum capacity block.
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP_W        = lpmc_pkg::CAP_W;
  localparam int LIMIT_W      = lpmc_pkg::LIMIT_W;
  localparam int ADDR_W       = lpmc_pkg::ADDR_W;
  localparam int DATA_W       = lpmc_pkg::DATA_W;
  localparam int STORE_DEPTH  = 1024;
  localparam int LEN_W        = 16;
  localparam int RANDOM_ITEMS = 550;
  localparam int QUIET_LIMIT  = 200000;
  localparam int PLAN_ROWS    = 30;

  typedef enum logic {ROW_ITEM, ROW_LIMIT} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    int unsigned      value;
    bit               last;
    bit               typed;
    logic [CAP_W-1:0] cap;
  } plan_row_t;

  typedef struct {
    logic [CAP_W-1:0] cap;
    logic             ovf;
  } cap_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [LEN_W-1:0]    item_length_i = '0;
  logic                last_item_i   = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [CAP_W-1:0]    min_capacity_o;
  logic                overflow_o;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ADDR_W-1:0]   paddr         = '0;
  logic [DATA_W-1:0]   pwdata        = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic [LEN_W-1:0]    stored_lens[$];
  bit                  lost_items    = 1'b0;
  logic [LIMIT_W-1:0]  group_limit   = LIMIT_W'(1);
  cap_result_t         pending_caps[$];
  int                  mismatches    = 0;
  int                  quiet_cycles  = 0;
  bit                  calm          = 1'b0;

  plan_row_t plan [0:PLAN_ROWS-1] = '{
    '{ROW_ITEM,  5,     1'b1, 1'b1, CAP_W'(5)},
    '{ROW_ITEM,  0,     1'b1, 1'b1, CAP_W'(1)},
    '{ROW_ITEM,  65535, 1'b0, 1'b0, CAP_W'(0)},
    '{ROW_ITEM,  65535, 1'b1, 1'b1, CAP_W'(131070)},
    '{ROW_ITEM,  1,     1'b0, 1'b0, CAP_W'(0)},
    '{ROW_ITEM,  0,     1'b0, 1'b0, CAP_W'(0)},
    '{ROW_ITEM,  1,     1'b1, 1'b1, CAP_W'(2)},
    '{ROW_LIMIT, 0,     1'b0, 1'b0, CAP_W'(0)},
    '{ROW_ITEM,  7,     1'b0, 1'b0, CAP_W'(0)},
    '{ROW_ITEM,  9,     1'b1, 1'b1, CAP_W'(16)},
    '{ROW_LIMIT, 3,     1'b0, 1'b0, CAP_W'(0)},
    '{ROW_ITEM,  4,     1'b0, 1'b0, CAP_W'(0)},
    '{ROW_ITEM,  4,     1'b0, 1'b0, CAP_W'(0)},
    '{ROW_ITEM,  4,     1'b0, 1'b0, CAP_W'(0)},
    '{ROW_ITEM,  4,     1'b1, 1'b0, CAP_W'(0)},
    '{ROW_ITEM,  10,    1'b0, 1'b0, CAP_W'(0)},
    '{ROW_ITEM,  1,     1'b0, 1'b0, CAP_W'(0)},
    '{ROW_ITEM,  1,     1'b0, 1'b0, CAP_W'(0)},
    '{ROW_ITEM,  10,    1'b1, 1'b0, CAP_W'(0)},
    '{ROW_LIMIT, 2047,  1'b0, 1'b0, CAP_W'(0)},
    '{ROW_ITEM,  3,     1'b0, 1'b0, CAP_W'(0)},
    '{ROW_ITEM,  65535, 1'b0, 1'b0, CAP_W'(0)},
    '{ROW_ITEM,  2,     1'b1, 1'b1, CAP_W'(65535)},
    '{ROW_LIMIT, 1024,  1'b0, 1'b0, CAP_W'(0)},
    '{ROW_ITEM,  0,     1'b0, 1'b0, CAP_W'(0)},
    '{ROW_ITEM,  0,     1'b1, 1'b1, CAP_W'(1)},
    '{ROW_LIMIT, 2,     1'b0, 1'b0, CAP_W'(0)},
    '{ROW_ITEM,  100,   1'b0, 1'b0, CAP_W'(0)},
    '{ROW_ITEM,  1,     1'b0, 1'b0, CAP_W'(0)},
    '{ROW_ITEM,  1,     1'b1, 1'b0, CAP_W'(0)}
  };

  linear_partition_min_capacity_top #(
    .MAX_ITEMS  (STORE_DEPTH),
    .LENGTH_BITS(LEN_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .item_length_i (item_length_i),
    .last_item_i   (last_item_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .min_capacity_o(min_capacity_o),
    .overflow_o    (overflow_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit greedy_fits(input longint unsigned cap, input longint unsigned allowed);
    longint unsigned acc;
    longint unsigned groups;
    acc    = 0;
    groups = 1;
    foreach (stored_lens[k]) begin
      if (stored_lens[k] > cap) return 1'b0;
      acc += stored_lens[k];
      if (acc > cap) begin
        acc = stored_lens[k];
        groups++;
      end
    end
    return groups <= allowed;
  endfunction

  function automatic logic [CAP_W-1:0] search_capacity();
    longint unsigned total;
    longint unsigned allowed;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned best;
    total = 0;
    foreach (stored_lens[k]) total += stored_lens[k];
    allowed = (group_limit == 0) ? 1 : group_limit;
    lo      = 1;
    hi      = (total == 0) ? 1 : total;
    best    = hi;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (greedy_fits(mid, allowed)) begin
        best = mid;
        hi   = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return best[CAP_W-1:0];
  endfunction

  function automatic void absorb_item(input logic [LEN_W-1:0] len, input logic last);
    if (stored_lens.size() < STORE_DEPTH) stored_lens.push_back(len);
    else lost_items = 1'b1;
    if (last) begin
      pending_caps.push_back('{cap: search_capacity(), ovf: lost_items});
      stored_lens.delete();
      lost_items = 1'b0;
    end
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(19)) inside
      0:       return '0;
      [1:2]:   return '1;
      [3:10]:  return LEN_W'($urandom_range(1, 16));
      default: return LEN_W'($urandom);
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(5))
      0:       return '0;
      1:       return LIMIT_W'(1);
      2:       return '1;
      3:       return LIMIT_W'($urandom_range(2, 4));
      4:       return LIMIT_W'($urandom_range(2, 16));
      default: return LIMIT_W'($urandom_range(1, 2047));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatches++;
    $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic push_item(input logic [LEN_W-1:0] len, input logic last);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 13) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    item_length_i <= len;
    last_item_i   <= last;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_item(len, last);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_caps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_group_limit(input logic [LIMIT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({lpmc_pkg::REG_GROUP_LIMIT, 2'b00});
    pwdata  <= DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    group_limit = value;
  endtask

  always @(posedge clk_i) begin
    cap_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_caps.size() == 0) begin
        report_mismatch("result beat with nothing pending", min_capacity_o, 0);
      end else begin
        want = pending_caps.pop_front();
        if (min_capacity_o !== want.cap)
          report_mismatch("min_capacity", min_capacity_o, want.cap);
        if (overflow_o !== want.ovf)
          report_mismatch("overflow", overflow_o, want.ovf);
      end
    end
    out_ready_i <= calm || ($urandom_range(99) >= 13);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int sent;
    int sets;
    int n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_LIMIT) begin
        drain_results();
        write_group_limit(LIMIT_W'(plan[r].value));
      end else begin
        push_item(LEN_W'(plan[r].value), plan[r].last);
        if (plan[r].typed) pending_caps[pending_caps.size()-1] = '{plan[r].cap, 1'b0};
      end
    end

    // One set runs past the store: the beat that carries the last flag is dropped too.
    drain_results();
    write_group_limit(LIMIT_W'(5));
    calm = 1'b1;
    for (int k = 1; k <= STORE_DEPTH + 2; k++) push_item(pick_length(), k == STORE_DEPTH + 2);
    drain_results();
    calm = 1'b0;

    sent = 0;
    sets = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sets % 6 == 0) begin
        drain_results();
        write_group_limit(pick_limit());
      end else if ($urandom_range(7) == 0) begin
        drain_results();
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      for (int k = 1; k <= n; k++) push_item(pick_length(), k == n);
      sent += n;
      sets++;
    end

    in_valid_i <= 1'b0;
    while (pending_caps.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== linear_partition_min_capacity_top.f =====
hdl/lpmc_pkg.sv
hdl/lpmc_ram.sv
hdl/lpmc_ctrl.sv
hdl/lpmc_dp.sv
hdl/linear_partition_min_capacity_top.sv
verif/testbench.sv
